// ===== sv/nps_pkg.sv =====
package nps_pkg;

  localparam int unsigned A_W    = 34;
  localparam int unsigned B_W    = 32;
  localparam int unsigned PROD_W = A_W + B_W;
  localparam int unsigned NUM_W  = 67;
  localparam int unsigned DEN_W  = 68;

  localparam logic [31:0] COUNT_LIMIT   = 32'h7FFF_FFFF;
  localparam logic [31:0] DEFAULT_VOCAB = 32'd256;

  localparam logic [1:0] KIND_ADD_ONE     = 2'd0;
  localparam logic [1:0] KIND_WITTEN_BELL = 2'd1;
  localparam logic [1:0] KIND_GOOD_TURING = 2'd2;
  localparam logic [1:0] KIND_KNESER_NEY  = 2'd3;

  localparam logic [1:0] REG_KIND  = 2'd0;
  localparam logic [1:0] REG_VOCAB = 2'd1;

  // num = a1*b1 + add, den = (a2*b2) << (sh ? 2 : 0)
  typedef struct packed {
    logic [A_W-1:0] a1;
    logic [B_W-1:0] b1;
    logic [A_W-1:0] add;
    logic [A_W-1:0] a2;
    logic [B_W-1:0] b2;
    logic           sh;
  } ops_t;

  typedef struct packed {
    logic [PROD_W-1:0] p1;
    logic [A_W-1:0]    add;
    logic [PROD_W-1:0] p2;
    logic              sh;
  } prod_t;

endpackage

// ===== sv/nps_front.sv =====
module nps_front import nps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [1:0]       kind,
  input  logic [31:0]      vocab,
  input  logic [31:0]      c_in,
  input  logic [31:0]      t_in,
  input  logic [31:0]      d_in,
  input  logic [31:0]      nr_in,
  input  logic [31:0]      nr1_in,
  output logic             out_vld,
  output logic [DEN_W-1:0] rem0,
  output logic [DEN_W-1:0] den,
  output logic [7:0]       num_lo,
  output logic             sat
);

  logic [31:0] c, t, v, nrm, unseen;
  logic [32:0] t_plus_d, t_plus_v;
  ops_t        ops_next, ops;
  prod_t       prod;
  logic [NUM_W-1:0] num3;
  logic [DEN_W-1:0] den3;
  logic v1, v2, v3;

  always_comb begin
    c        = (c_in > COUNT_LIMIT) ? 32'd0 : c_in;
    t        = (t_in == 32'd0) ? 32'd1 : t_in;
    v        = (vocab == 32'd0) ? DEFAULT_VOCAB : vocab;
    nrm      = (nr_in == 32'd0) ? 32'd1 : nr_in;
    unseen   = (v > d_in) ? v - d_in : 32'd1;
    t_plus_d = {1'b0, t} + {1'b0, d_in};
    t_plus_v = {1'b0, t} + {1'b0, v};
    ops_next = '0;
    ops_next.b1 = 32'd1;
    ops_next.b2 = 32'd1;
    unique case (kind)
      KIND_WITTEN_BELL: begin
        if (d_in == 32'd0) begin
          ops_next.a1 = 34'd1;
          ops_next.a2 = {2'b0, v};
        end else if (c != 32'd0) begin
          ops_next.a1 = {2'b0, c};
          ops_next.a2 = {1'b0, t_plus_d};
        end else begin
          ops_next.a1 = {2'b0, d_in};
          ops_next.a2 = {1'b0, t_plus_d};
          ops_next.b2 = unseen;
        end
      end
      KIND_GOOD_TURING: begin
        if (c == 32'd0) begin
          ops_next.a1 = {2'b0, nrm};
          ops_next.a2 = {2'b0, t};
        end else if (nr1_in == 32'd0) begin
          ops_next.a1 = {2'b0, c};
          ops_next.a2 = {2'b0, t};
        end else begin
          ops_next.a1 = {2'b0, c} + 34'd1;
          ops_next.b1 = nr1_in;
          ops_next.a2 = {2'b0, nrm};
          ops_next.b2 = t;
        end
      end
      KIND_KNESER_NEY: begin
        ops_next.a2  = {2'b0, t};
        ops_next.b2  = v;
        ops_next.sh  = 1'b1;
        ops_next.add = {2'b0, d_in} + {1'b0, d_in, 1'b0};
        if (c != 32'd0) begin
          ops_next.a1 = {c, 2'b0} - 34'd3;
          ops_next.b1 = v;
        end else begin
          ops_next.a1 = 34'd0;
        end
      end
      default: begin
        ops_next.a1 = {2'b0, c} + 34'd1;
        ops_next.a2 = {1'b0, t_plus_v};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      out_vld <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // operand select
      ops <= ops_next;
      // two multipliers
      prod.p1  <= ops.a1 * ops.b1;
      prod.p2  <= ops.a2 * ops.b2;
      prod.add <= ops.add;
      prod.sh  <= ops.sh;
      // numerator add, denominator shift
      num3 <= {1'b0, prod.p1} + {{(NUM_W-A_W){1'b0}}, prod.add};
      den3 <= prod.sh ? {prod.p2, 2'b00} : {2'b00, prod.p2};
      // overflow check: quotient >= 256
      sat    <= {9'd0, num3} >= {den3, 8'd0};
      rem0   <= {9'd0, num3[NUM_W-1:8]};
      den    <= den3;
      num_lo <= num3[7:0];
    end
  end

endmodule

// ===== sv/nps_div_stage.sv =====
module nps_div_stage import nps_pkg::*; #(
  parameter int unsigned Q_W = 40,
  parameter int unsigned BIT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [DEN_W-1:0] in_rem,
  input  logic [DEN_W-1:0] in_den,
  input  logic [Q_W-1:0]   in_q,
  input  logic [7:0]       in_num_lo,
  input  logic             in_sat,
  input  logic             bit_in,
  output logic             out_vld,
  output logic [DEN_W-1:0] out_rem,
  output logic [DEN_W-1:0] out_den,
  output logic [Q_W-1:0]   out_q,
  output logic [7:0]       out_num_lo,
  output logic             out_sat
);

  logic [DEN_W:0] trial, diff;
  logic           take;
  logic [Q_W-1:0] q_next;

  always_comb begin
    trial  = {in_rem, bit_in};
    take   = trial >= {1'b0, in_den};
    diff   = trial - {1'b0, in_den};
    q_next = in_q;
    q_next[BIT] = take;
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem      <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      out_den      <= in_den;
      out_q        <= q_next;
      out_num_lo   <= in_num_lo;
      out_sat      <= in_sat;
    end
  end

endmodule

// ===== sv/ngram_probability_smoother_unit.sv =====
// channel | dir | accepted when           | beat
// s_*     | in  | s_tvalid & s_tready     | tdata: count, total, distinct, nr, nr1
// m_*     | out | m_tvalid & m_tready     | tdata: probability, saturated
// cfg_*   | in  | cfg_valid & cfg_ready   | index 0 kind, 1 vocabulary size
//
// one beat per cycle while m_tready does not hold the pipeline; four front
// stages with the two multipliers, then one restoring divide step per
// quotient bit. the whole pipeline advances together; it holds while a
// result waits on m_tready and bubbles are kept.
// rst is synchronous, clears valid bits and loads kind 0, vocabulary 256.
// cfg_ready is always high.
module ngram_probability_smoother_unit import nps_pkg::*; #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // outcome_count, total_count, distinct_seen, freq_at_count, freq_at_next_count
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // probability[39:0], saturated[40], zero pad
  output logic [47:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int unsigned Q_W = 8 + FRAC_BITS;

  logic [1:0]  kind;
  logic [31:0] vocab;
  logic        en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind  <= KIND_ADD_ONE;
      vocab <= DEFAULT_VOCAB;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KIND:  kind  <= cfg_data[1:0];
        REG_VOCAB: vocab <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: move unless the result register is stuck
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic             vld_a [0:Q_W];
  logic [DEN_W-1:0] rem_a [0:Q_W];
  logic [DEN_W-1:0] den_a [0:Q_W];
  logic [Q_W-1:0]   q_a   [0:Q_W];
  logic [7:0]       lo_a  [0:Q_W];
  logic             sat_a [0:Q_W];

  nps_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(s_tvalid), .kind(kind), .vocab(vocab),
    .c_in(s_tdata[31:0]), .t_in(s_tdata[63:32]), .d_in(s_tdata[95:64]),
    .nr_in(s_tdata[127:96]), .nr1_in(s_tdata[159:128]),
    .out_vld(vld_a[0]), .rem0(rem_a[0]), .den(den_a[0]),
    .num_lo(lo_a[0]), .sat(sat_a[0])
  );
  assign q_a[0] = '0;

  // stage k produces quotient bit Q_W-1-k; the dividend is num << FRAC_BITS
  for (genvar k = 0; k < Q_W; k++) begin : g_div
    localparam int unsigned BIT = Q_W - 1 - k;
    logic bit_in;
    if (BIT >= FRAC_BITS) begin : g_num
      assign bit_in = lo_a[k][BIT - FRAC_BITS];
    end else begin : g_zero
      assign bit_in = 1'b0;
    end
    nps_div_stage #(.Q_W(Q_W), .BIT(BIT)) u_stage (
      .clk(clk), .rst(rst), .en(en),
      .in_vld(vld_a[k]), .in_rem(rem_a[k]), .in_den(den_a[k]), .in_q(q_a[k]),
      .in_num_lo(lo_a[k]), .in_sat(sat_a[k]), .bit_in(bit_in),
      .out_vld(vld_a[k+1]), .out_rem(rem_a[k+1]), .out_den(den_a[k+1]),
      .out_q(q_a[k+1]), .out_num_lo(lo_a[k+1]), .out_sat(sat_a[k+1])
    );
  end

  // saturate to the format maximum, then fit to the 40-bit field
  logic [Q_W-1:0]  q_sel;
  logic [Q_W+39:0] q_ext;

  assign q_sel    = sat_a[Q_W] ? {Q_W{1'b1}} : q_a[Q_W];
  assign q_ext    = {40'd0, q_sel};
  assign m_tvalid = vld_a[Q_W];
  assign m_tdata  = {7'd0, sat_a[Q_W], q_ext[39:0]};

endmodule

// ===== bench/smoother_checker.sv =====
`timescale 1ns / 100ps
module smoother_checker import nps_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [159:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [47:0]  m_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  localparam int FB = 32;

  logic [1:0]  kind_q;
  logic [31:0] vocab_q;
  logic [40:0] prob_fifo[$];

  // exact floor(num * 2^FB / den) with saturation at 2^(8+FB)-1
  function automatic logic [40:0] smooth_quot(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    logic [127:0] maxv;
    q = (num << FB) / den;
    maxv = (128'd1 << (8 + FB)) - 1;
    if (q > maxv) return {1'b1, maxv[39:0]};
    return {1'b0, q[39:0]};
  endfunction

  function automatic logic [40:0] smooth_prob(logic [159:0] beat);
    logic [127:0] c, t, d, nr, nr1, v, num, den, unseen, nrm;
    c = beat[31:0];
    t = beat[63:32];
    d = beat[95:64];
    nr = beat[127:96];
    nr1 = beat[159:128];
    v = vocab_q;
    if (c > COUNT_LIMIT) c = 0;
    if (t == 0) t = 1;
    if (v == 0) v = DEFAULT_VOCAB;
    nrm = (nr > 0) ? nr : 1;
    case (kind_q)
      KIND_WITTEN_BELL: begin
        if (d == 0) begin
          num = 1; den = v;
        end else if (c > 0) begin
          num = c; den = t + d;
        end else begin
          unseen = (v > d) ? v - d : 1;
          num = d; den = (t + d) * unseen;
        end
      end
      KIND_GOOD_TURING: begin
        if (c == 0) begin
          num = nrm; den = t;
        end else if (nr1 == 0) begin
          num = c; den = t;
        end else begin
          num = (c + 1) * nr1; den = nrm * t;
        end
      end
      KIND_KNESER_NEY: begin
        den = 4 * t * v;
        if (c > 0) num = (4 * c - 3) * v + 3 * d;
        else num = 3 * d;
      end
      default: begin
        num = c + 1; den = t + v;
      end
    endcase
    return smooth_quot(num, den);
  endfunction

  assign pending = prob_fifo.size();

  always @(posedge clk) begin
    logic [40:0] want;
    if (rst) begin
      kind_q <= KIND_ADD_ONE;
      vocab_q <= DEFAULT_VOCAB;
      fail_count <= 0;
      prob_fifo.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_KIND) kind_q <= cfg_data[1:0];
        else if (cfg_index == REG_VOCAB) vocab_q <= cfg_data;
      end
      if (s_tvalid && s_tready) prob_fifo.push_back(smooth_prob(s_tdata));
      if (m_tvalid && m_tready) begin
        if (prob_fifo.size() == 0) begin
          if (fail_count < 10) $display("unexpected beat %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = prob_fifo.pop_front();
          if (m_tdata[40:0] !== want || m_tdata[47:41] !== 7'd0) begin
            if (fail_count < 10)
              $display("mismatch: prob exp %h got %h, sat exp %b got %b",
                       want[39:0], m_tdata[39:0], want[40], m_tdata[40]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import nps_pkg::*;

  localparam int LATENCY = 4 + 8 + 32;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [47:0]  m_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  int           fail_count;
  int           pending;

  int send_idle_pct = 0;   // sender gap odds, percent
  int recv_stall_pct = 0;  // receiver stall odds, percent
  int hold_cycles = 0;     // long receiver hold-off request

  ngram_probability_smoother_unit dut (.*);

  smoother_checker chk (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    #60ms;
    $display("ngram_probability_smoother_unit verification failed");
    $finish;
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 0;
        hold_cycles = hold_cycles - 1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [31:0] rand_field();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return $urandom_range(5);
      5: return $urandom_range(1000);
      default: return $urandom;
    endcase
  endfunction

  // well-formed query: count within total, distinct within total
  function automatic logic [159:0] sane_query();
    logic [31:0] t, c, d;
    t = $urandom_range(1, 100000);
    c = $urandom_range(t);
    d = $urandom_range(c > 0 ? 1 : 0, t);
    return {32'($urandom_range(5000)), 32'($urandom_range(1, 5000)), d, t, c};
  endfunction

  task automatic send_beat(input logic [159:0] beat);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= beat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_all();
    int guard;
    s_tvalid <= 0;
    guard = 0;
    while (pending != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (pending != 0) begin
      $display("ngram_probability_smoother_unit verification failed");
      $finish;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] vocab_set[6];
    int phase;
    vocab_set = '{32'd0, 32'd1, 32'd256, 32'hFFFF_FFFF, 32'd50000, 32'd3};
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: default registers, then each kind with corner fields
    send_beat({32'd2, 32'd3, 32'd5, 32'd10, 32'd4});
    drain_all();
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_KIND, 32'(k));
      write_reg(REG_VOCAB, k == 0 ? 32'd0 : 32'hFFFF_FFFF);
      send_beat({32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
      send_beat({5{32'hFFFF_FFFF}});
      send_beat({32'd0, 32'd0, 32'd3, 32'd0, 32'h8000_0000});
      send_beat({32'd7, 32'd0, 32'd9, 32'd100, 32'h7FFF_FFFF});
      send_beat({32'd1, 32'd4, 32'd2, 32'd10, 32'd3});
      drain_all();
    end
    write_reg(REG_VOCAB, 32'd5);
    write_reg(REG_KIND, 32'(KIND_WITTEN_BELL));
    send_beat({32'd0, 32'd0, 32'd9, 32'd10, 32'd0}); // distinct beyond vocabulary
    drain_all();

    // random phases: idling patterns x register settings
    for (phase = 0; phase < 16; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      write_reg(REG_KIND, 32'(phase % 4));
      write_reg(REG_VOCAB, vocab_set[$urandom_range(5)]);
      if (phase == 4) hold_cycles = 300;  // fill the pipe, stall the input
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(99) < 70) send_beat(sane_query());
        else send_beat({rand_field(), rand_field(), rand_field(), rand_field(),
                        rand_field()});
      end
      drain_all();
    end

    if (fail_count == 0) begin
      $display("ngram_probability_smoother_unit verification clean");
    end else begin
      $display("ngram_probability_smoother_unit verification failed");
    end
    $finish;
  end

endmodule
